// ===== src/ffsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants, codes and controller/datapath types of the first-free
// slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int ROW_BITS  = 32;
    localparam int ROWS      = MAX_SLOTS / ROW_BITS;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int BIT_W     = $clog2(ROW_BITS);
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int STRIDE_W  = 13;
    localparam int OFF_W     = SLOT_W + STRIDE_W;
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE_STRIDE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic take;
        logic alloc_commit;
        logic free_commit;
        logic res_alloc;
        logic res_full;
        logic res_ignored;
    } ffsa_cmd_t;

    typedef struct packed {
        logic req_free;
        logic word_found;
        logic free_ok;
        logic bit_found;
    } ffsa_stat_t;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [ROW_BITS-1:0] vec);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

// ===== src/ffsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Request sequencer: accepts a request and steps the datapath through the
// search, commit and result phases.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire ffsa_stat_t stat,
    output logic            busy,
    output ffsa_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SEARCH  = 2'd1;
    localparam logic [1:0] S_ADDR    = 2'd2;
    localparam logic [1:0] S_RELEASE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.take = 1'b1;
                    if (stat.req_free)
                    begin
                        if (stat.free_ok)
                        begin
                            state_next = S_RELEASE;
                        end
                        else
                        begin
                            cmd.res_ignored = 1'b1;
                        end
                    end
                    else if (stat.word_found)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        cmd.res_full = 1'b1;
                    end
                end
            end
            S_SEARCH:
            begin
                if (stat.bit_found)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_ADDR;
                end
                else
                begin
                    cmd.res_full = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ADDR:
            begin
                cmd.res_alloc = 1'b1;
                state_next    = S_IDLE;
            end
            S_RELEASE:
            begin
                cmd.free_commit = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== src/ffsa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_dp
// Datapath: configuration registers, busy-bit memory with row summaries,
// first-fit search, address arithmetic and result registers.
// ----------------------------------------------------------------------------
module ffsa_dp
    import ffsa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ffsa_cmd_t            cmd,
    output ffsa_stat_t                stat,
    input  wire logic                 req_type,
    input  wire logic [SLOT_W-1:0]    free_index,
    input  wire logic                 handle_valid,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [SLOT_W-1:0]         slot_index,
    output logic [ADDR_W-1:0]         cpu_addr,
    output logic [ADDR_W-1:0]         gpu_addr,
    output logic                      gpu_addr_valid
);

    logic [COUNT_W-1:0]  slots_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                visible_reg;

    logic [ROW_BITS-1:0] mem [0:ROWS-1];
    logic [ROW_BITS-1:0] rdata_reg;
    logic                rvalid_reg;
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROWS-1:0]     row_full_reg;

    logic [ROW_W-1:0]    word_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [OFF_W-1:0]    off_reg;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   cpu_reg;
    logic [ADDR_W-1:0]   gpu_reg;
    logic                gav_reg;

    logic [COUNT_W-1:0]  count;
    logic [ROWS-1:0]     word_mask;
    logic [ROWS-1:0]     cand_rows;
    logic [ROW_W-1:0]    cand_row;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_BITS-1:0] bit_mask;
    logic [ROW_BITS-1:0] word_val;
    logic [ROW_BITS-1:0] free_bits;
    logic [BIT_W-1:0]    sel_bit;
    logic [SLOT_W-1:0]   sel_idx;
    logic                mem_we;
    logic [ROW_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]   off_ext;

    // clamp slot count
    assign count = (slots_reg > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : slots_reg;

    always_comb
    begin
        for (int w = 0; w < ROWS; w++)
        begin
            word_mask[w] = {1'b0, ROW_W'(w), {BIT_W{1'b0}}} < count;
        end
        for (int b = 0; b < ROW_BITS; b++)
        begin
            bit_mask[b] = {1'b0, word_reg, BIT_W'(b)} < count;
        end
    end

    assign cand_rows = ~row_full_reg & word_mask;
    assign cand_row  = lowest_set(cand_rows);
    assign rd_row    = req_type ? free_index[SLOT_W-1:BIT_W] : cand_row;

    assign word_val  = rvalid_reg ? rdata_reg : '0;
    assign free_bits = ~word_val & bit_mask;
    assign sel_bit   = lowest_set(free_bits);
    assign sel_idx   = {word_reg, sel_bit};

    assign stat.req_free   = req_type;
    assign stat.word_found = |cand_rows;
    assign stat.free_ok    = handle_valid && ({1'b0, free_index} < count);
    assign stat.bit_found  = |free_bits;

    assign mem_we    = cmd.alloc_commit | cmd.free_commit;
    assign mem_wdata = cmd.alloc_commit ? (word_val | (ROW_BITS'(1) << sel_bit))
                                        : (word_val & ~(ROW_BITS'(1) << bit_reg));
    assign off_ext   = {{(ADDR_W-OFF_W){1'b0}}, off_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg   <= COUNT_W'(MAX_SLOTS);
            stride_reg  <= STRIDE_W'(32);
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            visible_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLOTS_IN_USE:   slots_reg    <= cfg_data[COUNT_W-1:0];
                REG_HANDLE_STRIDE:  stride_reg   <= cfg_data[STRIDE_W-1:0];
                REG_CPU_BASE:       cpu_base_reg <= cfg_data;
                REG_GPU_BASE:       gpu_base_reg <= cfg_data;
                REG_SHADER_VISIBLE: visible_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[word_reg] <= mem_wdata;
        end
        if (cmd.take)
        begin
            rdata_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                rvalid_reg <= row_valid_reg[rd_row];
            end
            if (mem_we)
            begin
                row_valid_reg[word_reg] <= 1'b1;
                row_full_reg[word_reg]  <= cmd.alloc_commit & (&mem_wdata);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            word_reg <= rd_row;
            bit_reg  <= free_index[BIT_W-1:0];
        end
        if (cmd.alloc_commit)
        begin
            idx_reg <= sel_idx;
            off_reg <= OFF_W'(sel_idx) * OFF_W'(stride_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_alloc | cmd.res_full | cmd.res_ignored | cmd.free_commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_alloc)
        begin
            status_reg <= ST_ALLOCATED;
            slot_reg   <= idx_reg;
            cpu_reg    <= cpu_base_reg + off_ext;
            gpu_reg    <= visible_reg ? (gpu_base_reg + off_ext) : '0;
            gav_reg    <= visible_reg;
        end
        else if (cmd.res_full | cmd.res_ignored | cmd.free_commit)
        begin
            status_reg <= cmd.res_full ? ST_FULL : (cmd.free_commit ? ST_FREED : ST_IGNORED);
            slot_reg   <= '0;
            cpu_reg    <= '0;
            gpu_reg    <= '0;
            gav_reg    <= 1'b0;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign slot_index     = slot_reg;
    assign cpu_addr       = cpu_reg;
    assign gpu_addr       = gpu_reg;
    assign gpu_addr_valid = gav_reg;

endmodule
`default_nettype wire

// ===== src/first_free_slot_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_free_slot_allocator_core
// Bitmap first-fit descriptor slot allocator: allocate the lowest free slot
// and return its CPU/GPU addresses, or release a slot.
//
//   channel   handshake           payload
//   request   start / busy        req_type, free_index, handle_valid
//   result    done (1 cycle)      status, slot_index, cpu_addr, gpu_addr,
//                                 gpu_addr_valid
//   config    cfg_we              cfg_index, cfg_data
//
// Allocate: row summary pick and row read, then bit pick, commit and offset
// multiply, then address add; FULL after the read if the candidate row is the
// partly used last row with no free slot in range, or from the summary alone if
// no row in range has room. Free: row read-modify-write for a valid in-range
// handle. Done is registered from the last step, cannot be stalled, and a new
// request is taken while it is high. Reset frees all slots via per-row valid bits.
// ----------------------------------------------------------------------------
module first_free_slot_allocator_core
    import ffsa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 req_type,
    input  wire logic [SLOT_W-1:0]    free_index,
    input  wire logic                 handle_valid,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [SLOT_W-1:0]         slot_index,
    output logic [ADDR_W-1:0]         cpu_addr,
    output logic [ADDR_W-1:0]         gpu_addr,
    output logic                      gpu_addr_valid
);

    ffsa_cmd_t  cmd;
    ffsa_stat_t stat;

    ffsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    ffsa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .free_index     (free_index),
        .handle_valid   (handle_valid),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .slot_index     (slot_index),
        .cpu_addr       (cpu_addr),
        .gpu_addr       (gpu_addr),
        .gpu_addr_valid (gpu_addr_valid)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in flight");

    a_nonalloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_ALLOCATED |->
            slot_index == '0 && cpu_addr == '0 && gpu_addr == '0 && !gpu_addr_valid)
        else $error("non-allocation result carries a nonzero payload");

    a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.alloc_commit, cmd.free_commit, cmd.res_alloc,
                  cmd.res_full, cmd.res_ignored}))
        else $error("more than one datapath action in a cycle");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("controller left idle without a request");

endmodule
`default_nettype wire
